@@ src/lvp_pkg.sv @@
// Shared types, constants and fixed-point helpers for the Langevin-Verlet
// position step. No dependencies; every other file imports this package.
package lvp_pkg;

	localparam int DEF_AXES      = 3;
	localparam int DEF_FRAC_BITS = 16;
	localparam int PIPE_DEPTH    = 6;
	localparam int CFG_AW        = 4;

	localparam logic signed [31:0] RST_COEF_A    = 32'sd65536;
	localparam logic signed [31:0] RST_COEF_B    = 32'sd65536;
	localparam logic        [30:0] RST_TIME_STEP = 31'd655;
	localparam logic        [30:0] RST_BOX       = 31'd655360;
	localparam logic        [30:0] RST_AMP       = 31'd65536;

	typedef enum logic [CFG_AW-1:0] {
		REG_COEF_A    = 4'd0,
		REG_COEF_B    = 4'd1,
		REG_TIME_STEP = 4'd2,
		REG_BOX_X     = 4'd3,
		REG_BOX_Y     = 4'd4,
		REG_BOX_Z     = 4'd5,
		REG_AMP0      = 4'd6,
		REG_AMP1      = 4'd7
	} reg_idx_t;

	// Item state after the second register stage.
	typedef struct packed {
		logic               regular;
		logic signed [31:0] x;
		logic signed [31:0] n_now;
		logic signed [31:0] nhalf;
		logic signed [31:0] xp_u;
		logic signed [31:0] bdt2;
		logic signed [31:0] kamp;
		logic signed [31:0] bx2;
		logic signed [31:0] force_v;
		logic        [30:0] box;
	} lvp_s2_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -64'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	// Fixed-point product: floor shift, then saturate.
	function automatic logic signed [31:0] mul_q(input logic signed [31:0] a,
			input logic signed [31:0] b, input int frac);
		logic signed [63:0] p;
		p = a * b;
		return sat32(p >>> frac);
	endfunction

endpackage

@@ src/langevin_verlet_position_step.sv @@
// Top level of the Langevin-Verlet position step: stream handshake, stage
// valid/ready chain. Depends on lvp_pkg, lvp_cfg, lvp_front, lvp_back.
//
//  channel   | direction | beat contents
//  ----------+-----------+------------------------------------------------
//  s_axis    | in        | tdata: position, prev_position, force_req,
//            |           |        noise_now, noise_before; tuser: cmd,
//            |           |        axis, particle_type
//  m_axis    | out       | tdata: new_position, history_position,
//            |           |        history_noise
//  cfg       | in        | write enable, register index, write data
//
// Each beat passes six register stages, and a new beat can be taken every
// cycle while the output side is ready. Depth is set by the chain of
// multiplications (dt^2, then b*dt^2, then times force) and the saturating
// sum plus wrap behind it.
// Each stage holds while the stage after it is full and stalled, so bubbles
// are squeezed out and input is still taken while a result waits.
// Reset (arst_n low) empties the pipeline and loads the register defaults.
module langevin_verlet_position_step #(
	parameter int AXES      = lvp_pkg::DEF_AXES,
	parameter int FRAC_BITS = lvp_pkg::DEF_FRAC_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration write port
	input  logic                       cfg_we,
	input  logic [lvp_pkg::CFG_AW-1:0] cfg_addr,
	input  logic [31:0]                cfg_wdata,
	// input stream
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// position, prev_position, force_req, noise_now, noise_before
	input  logic [159:0]               s_axis_tdata,
	// cmd, axis[1:0], particle_type
	input  logic [3:0]                 s_axis_tuser,
	// output stream
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// new_position, history_position, history_noise
	output logic [95:0]                m_axis_tdata
);
	import lvp_pkg::*;

	logic signed [31:0] coef_a, coef_b;
	logic [30:0]        time_step;
	logic [30:0]        box_len [AXES];
	logic [30:0]        amp [2];

	logic [PIPE_DEPTH:1] vld_q;
	logic [PIPE_DEPTH:1] rdy;
	logic [PIPE_DEPTH:0] vld_in;

	lvp_s2_t            s2;
	logic signed [31:0] new_position, history_position, history_noise;

	lvp_cfg #(.AXES(AXES)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.we        (cfg_we),
		.addr      (cfg_addr),
		.wdata     (cfg_wdata),
		.coef_a    (coef_a),
		.coef_b    (coef_b),
		.time_step (time_step),
		.box_len   (box_len),
		.amp       (amp)
	);

	// A stage loads when it is empty or its content moves on this cycle.
	always_comb begin
		rdy[PIPE_DEPTH] = !vld_q[PIPE_DEPTH] || m_axis_tready;
		for (int k = PIPE_DEPTH - 1; k >= 1; k--)
			rdy[k] = !vld_q[k] || rdy[k+1];
	end

	assign vld_in = {vld_q, s_axis_tvalid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= PIPE_DEPTH; k++)
				if (rdy[k])
					vld_q[k] <= vld_in[k-1];
		end
	end

	assign s_axis_tready = rdy[1];
	assign m_axis_tvalid = vld_q[PIPE_DEPTH];

	lvp_front #(.AXES(AXES), .FRAC_BITS(FRAC_BITS)) u_front (
		.clk           (clk),
		.ld_s1         (rdy[1]),
		.ld_s2         (rdy[2]),
		.cmd           (s_axis_tuser[0]),
		.axis          (s_axis_tuser[2:1]),
		.particle_type (s_axis_tuser[3]),
		.position      (s_axis_tdata[31:0]),
		.prev_position (s_axis_tdata[63:32]),
		.force_req     (s_axis_tdata[95:64]),
		.noise_now     (s_axis_tdata[127:96]),
		.noise_before  (s_axis_tdata[159:128]),
		.coef_b        (coef_b),
		.time_step     (time_step),
		.box_len       (box_len),
		.amp           (amp),
		.s2            (s2)
	);

	lvp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk              (clk),
		.ld_s3            (rdy[3]),
		.ld_s4            (rdy[4]),
		.ld_s5            (rdy[5]),
		.ld_s6            (rdy[6]),
		.s2               (s2),
		.coef_a           (coef_a),
		.new_position     (new_position),
		.history_position (history_position),
		.history_noise    (history_noise)
	);

	assign m_axis_tdata = {history_noise, history_position, new_position};

endmodule

@@ src/lvp_cfg.sv @@
// Configuration register file of the Langevin-Verlet position step.
// Depends on lvp_pkg.
module lvp_cfg #(
	parameter int AXES = lvp_pkg::DEF_AXES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       we,
	input  logic [lvp_pkg::CFG_AW-1:0] addr,
	input  logic [31:0]                wdata,
	output logic signed [31:0]         coef_a,
	output logic signed [31:0]         coef_b,
	output logic [30:0]                time_step,
	output logic [30:0]                box_len [AXES],
	output logic [30:0]                amp [2]
);
	import lvp_pkg::*;

	logic signed [31:0] coef_a_q, coef_b_q;
	logic [30:0]        dt_q;
	logic [30:0]        box_q [AXES];
	logic [30:0]        amp_q [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q <= RST_COEF_A;
			coef_b_q <= RST_COEF_B;
			dt_q     <= RST_TIME_STEP;
			amp_q[0] <= RST_AMP;
			amp_q[1] <= RST_AMP;
			for (int i = 0; i < AXES; i++)
				box_q[i] <= RST_BOX;
		end else if (we) begin
			unique case (addr)
				REG_COEF_A:    coef_a_q <= wdata;
				REG_COEF_B:    coef_b_q <= wdata;
				REG_TIME_STEP: dt_q     <= wdata[30:0];
				REG_AMP0:      amp_q[0] <= wdata[30:0];
				REG_AMP1:      amp_q[1] <= wdata[30:0];
				default: ;
			endcase
			// box registers beyond the axis count are dropped
			for (int i = 0; i < AXES; i++)
				if (addr == CFG_AW'(REG_BOX_X) + CFG_AW'(i))
					box_q[i] <= wdata[30:0];
		end
	end

	assign coef_a    = coef_a_q;
	assign coef_b    = coef_b_q;
	assign time_step = dt_q;
	assign box_len   = box_q;
	assign amp       = amp_q;

endmodule

@@ src/lvp_front.sv @@
// Stages 1 and 2: coefficient products, noise halving and unwrap of the
// previous position. Depends on lvp_pkg.
module lvp_front #(
	parameter int AXES      = lvp_pkg::DEF_AXES,
	parameter int FRAC_BITS = lvp_pkg::DEF_FRAC_BITS
) (
	input  logic               clk,
	input  logic               ld_s1,
	input  logic               ld_s2,
	input  logic               cmd,
	input  logic [1:0]         axis,
	input  logic               particle_type,
	input  logic signed [31:0] position,
	input  logic signed [31:0] prev_position,
	input  logic signed [31:0] force_req,
	input  logic signed [31:0] noise_now,
	input  logic signed [31:0] noise_before,
	input  logic signed [31:0] coef_b,
	input  logic [30:0]        time_step,
	input  logic [30:0]        box_len [AXES],
	input  logic [30:0]        amp [2],
	output lvp_pkg::lvp_s2_t   s2
);
	import lvp_pkg::*;

	logic [30:0]        box_sel;
	logic signed [32:0] nsum, d;
	logic signed [31:0] dt_s;

	logic               regular_s1;
	logic signed [31:0] x_s1, xp_s1, f_s1, nn_s1, nhalf_s1, dt2_s1, bdt_s1, bx_s1;
	logic signed [32:0] d_s1;
	logic [30:0]        box_s1, amp_s1;

	logic [29:0]        half;
	logic signed [32:0] half_pos, half_neg, xp_plus, xp_minus, bx_dbl;
	logic signed [31:0] xp_u;

	always_comb begin
		// out-of-range axis codes fall to the last box register
		box_sel = box_len[AXES-1];
		for (int i = 0; i < AXES - 1; i++)
			if (axis == 2'(i))
				box_sel = box_len[i];
	end

	assign dt_s = $signed({1'b0, time_step});
	assign nsum = 33'(noise_now) + (cmd ? 33'(noise_before) : 33'sd0);
	assign d    = 33'(position) - 33'(prev_position);

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			regular_s1 <= cmd;
			x_s1       <= position;
			xp_s1      <= prev_position;
			f_s1       <= force_req;
			nn_s1      <= noise_now;
			nhalf_s1   <= nsum[32:1];
			d_s1       <= d;
			box_s1     <= box_sel;
			amp_s1     <= amp[particle_type];
			dt2_s1     <= mul_q(dt_s, dt_s, FRAC_BITS);
			bdt_s1     <= mul_q(coef_b, dt_s, FRAC_BITS);
			bx_s1      <= mul_q(coef_b, position, FRAC_BITS);
		end
	end

	assign half     = box_s1[30:1];
	assign half_pos = $signed({3'b000, half});
	assign half_neg = -half_pos;
	assign xp_plus  = 33'(xp_s1) + $signed({2'b00, box_s1});
	assign xp_minus = 33'(xp_s1) - $signed({2'b00, box_s1});
	assign bx_dbl   = {bx_s1, 1'b0};

	always_comb begin
		xp_u = xp_s1;
		if (d_s1 > half_pos)
			xp_u = sat32(64'(xp_plus));
		else if (d_s1 < half_neg)
			xp_u = sat32(64'(xp_minus));
	end

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			s2.regular <= regular_s1;
			s2.x       <= x_s1;
			s2.n_now   <= nn_s1;
			s2.nhalf   <= nhalf_s1;
			s2.xp_u    <= xp_u;
			s2.bdt2    <= mul_q(coef_b, dt2_s1, FRAC_BITS);
			s2.kamp    <= mul_q(bdt_s1, $signed({1'b0, amp_s1}), FRAC_BITS);
			s2.bx2     <= sat32(64'(bx_dbl));
			s2.force_v <= f_s1;
			s2.box     <= box_s1;
		end
	end

endmodule

@@ src/lvp_back.sv @@
// Stages 3 to 6: term products, saturating sum and wrap into the box.
// Depends on lvp_pkg.
module lvp_back #(
	parameter int FRAC_BITS = lvp_pkg::DEF_FRAC_BITS
) (
	input  logic               clk,
	input  logic               ld_s3,
	input  logic               ld_s4,
	input  logic               ld_s5,
	input  logic               ld_s6,
	input  lvp_pkg::lvp_s2_t   s2,
	input  logic signed [31:0] coef_a,
	output logic signed [31:0] new_position,
	output logic signed [31:0] history_position,
	output logic signed [31:0] history_noise
);
	import lvp_pkg::*;

	logic               regular_s3;
	logic signed [31:0] x_s3, nn_s3, bx2_s3, ax_s3, drift_s3, kick_s3;
	logic [30:0]        box_s3, box_s4, box_s5;
	logic signed [31:0] x_s4, nn_s4, x_s5, nn_s5, sum_s5;
	logic signed [32:0] u_s4, v_s4;
	logic signed [32:0] box_ext, sum_ext;
	logic signed [32:0] wrapped;

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			regular_s3 <= s2.regular;
			x_s3       <= s2.x;
			nn_s3      <= s2.n_now;
			bx2_s3     <= s2.bx2;
			box_s3     <= s2.box;
			ax_s3      <= mul_q(coef_a, s2.xp_u, FRAC_BITS);
			drift_s3   <= mul_q(s2.bdt2, s2.force_v, FRAC_BITS);
			kick_s3    <= mul_q(s2.kamp, s2.nhalf, FRAC_BITS);
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s4) begin
			x_s4   <= x_s3;
			nn_s4  <= nn_s3;
			box_s4 <= box_s3;
			u_s4   <= regular_s3 ? (33'(bx2_s3) - 33'(ax_s3)) : 33'(x_s3);
			v_s4   <= 33'(drift_s3) + 33'(kick_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s5) begin
			x_s5   <= x_s4;
			nn_s5  <= nn_s4;
			box_s5 <= box_s4;
			sum_s5 <= sat32(64'(u_s4) + 64'(v_s4));
		end
	end

	assign box_ext = $signed({2'b00, box_s5});
	assign sum_ext = 33'(sum_s5);

	always_comb begin
		wrapped = sum_ext;
		if (sum_ext > box_ext)
			wrapped = sum_ext - box_ext;
		else if (sum_ext < 33'sd0)
			wrapped = sum_ext + box_ext;
	end

	always_ff @(posedge clk) begin
		if (ld_s6) begin
			new_position     <= wrapped[31:0];
			history_position <= x_s5;
			history_noise    <= nn_s5;
		end
	end

endmodule

@@ src/lvp_checker.sv @@
// Port-level checks for the Langevin-Verlet position step, bound to the top
// level. Depends on lvp_pkg and langevin_verlet_position_step.
module lvp_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_axis_tvalid,
	input logic                       s_axis_tready,
	input logic                       m_axis_tvalid,
	input logic                       m_axis_tready,
	input logic [95:0]                m_axis_tdata
);
	import lvp_pkg::*;

	logic       in_beat, out_beat;
	logic [3:0] inflight_q;

	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign out_beat = m_axis_tvalid && m_axis_tready;

	// track beats taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			inflight_q <= '0;
		else if (in_beat && !out_beat)
			inflight_q <= inflight_q + 4'd1;
		else if (out_beat && !in_beat)
			inflight_q <= inflight_q - 4'd1;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output data changed while stalled");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 4'(PIPE_DEPTH))
		else $error("more beats in flight than pipeline stages");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> inflight_q != 4'd0)
		else $error("output beat with no input beat behind it");

endmodule

bind langevin_verlet_position_step lvp_checker u_lvp_checker (.*);

@@ tb/testbench.sv @@
// Self-checking bench for langevin_verlet_position_step: directed beats at reset
// settings, then register phases with random coordinates against a local predictor.
// Depends on lvp_pkg and the langevin_verlet_position_step RTL only.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lvp_pkg::*;

	localparam int FRAC        = DEF_FRAC_BITS;
	localparam int PHASES      = 10;
	localparam int PHASE_BEATS = 140;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;
	localparam int IDLE_PCT    = 18;
	localparam int REPORT_MAX  = 10;

	// index past the last register; writes to it must change nothing
	localparam logic [CFG_AW-1:0] REG_STRAY = 4'd11;

	// one coordinate as it travels on the input stream
	typedef struct packed {
		logic               regular;
		logic [1:0]         axis;
		logic               ptype;
		logic signed [31:0] pos;
		logic signed [31:0] prev_pos;
		logic signed [31:0] frc;
		logic signed [31:0] noise_new;
		logic signed [31:0] noise_old;
	} coord_beat_t;

	typedef struct packed {
		logic signed [31:0] new_pos;
		logic signed [31:0] hist_pos;
		logic signed [31:0] hist_noise;
	} coord_result_t;

	// register file image, same widths as the block holds them
	typedef struct packed {
		logic signed [31:0] coef_a;
		logic signed [31:0] coef_b;
		logic        [30:0] dt;
		logic        [30:0] box_x;
		logic        [30:0] box_y;
		logic        [30:0] box_z;
		logic        [30:0] amp0;
		logic        [30:0] amp1;
	} verlet_regs_t;

	// directed row: a beat plus, where obvious, its typed-in new position
	typedef struct packed {
		logic               regular;
		logic [1:0]         axis;
		logic               ptype;
		logic signed [31:0] pos;
		logic signed [31:0] prev_pos;
		logic signed [31:0] frc;
		logic signed [31:0] noise_new;
		logic signed [31:0] noise_old;
		logic               known;
		logic signed [31:0] known_pos;
	} directed_row_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         cfg_we;
	logic [3:0]   cfg_addr;
	logic [31:0]  cfg_wdata;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [159:0] s_axis_tdata;
	logic [3:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [95:0]  m_axis_tdata;

	verlet_regs_t  regs_now;
	coord_result_t pending_results[$];
	coord_result_t want_res;
	coord_result_t got_res;
	int            mismatches;
	int            cycle_count;
	int            hold_left;
	int            hold_reqs;
	int            holds_taken;
	bit            no_gaps;

	// Directed rows, all at reset settings (dt^2 truncates to 6 LSB, box 10.0).
	// Fields: regular, axis, type, pos, prev_pos, force, noise_new, noise_old,
	// known, typed new position.
	directed_row_t directed_rows [24] = '{
		// zero coordinate, first step: stays at zero
		'{1'b0, 2'd0, 1'b0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b1, 32'sh0},
		// 1.0 with no force and no noise stays put
		'{1'b0, 2'd1, 1'b1, 32'sh00010000, 32'sh0, 32'sh0, 32'sh0, 32'sh0,
			1'b1, 32'sh00010000},
		// just below zero wraps up by one box
		'{1'b0, 2'd2, 1'b0, 32'shffffffff, 32'sh0, 32'sh0, 32'sh0, 32'sh0,
			1'b1, 32'sh0009ffff},
		// one LSB past the box wraps down to one LSB
		'{1'b0, 2'd0, 1'b1, 32'sh000a0001, 32'sh0, 32'sh0, 32'sh0, 32'sh0,
			1'b1, 32'sh1},
		// exactly on the box edge is left alone
		'{1'b0, 2'd1, 1'b0, 32'sh000a0000, 32'sh0, 32'sh0, 32'sh0, 32'sh0,
			1'b1, 32'sh000a0000},
		// coordinate extremes, wrapped once only
		'{1'b0, 2'd2, 1'b1, 32'sh7fffffff, 32'sh0, 32'sh0, 32'sh0, 32'sh0,
			1'b1, 32'sh7ff5ffff},
		'{1'b0, 2'd0, 1'b0, 32'sh80000000, 32'sh0, 32'sh0, 32'sh0, 32'sh0,
			1'b1, 32'sh800a0000},
		// regular step, everything zero
		'{1'b1, 2'd0, 1'b0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b1, 32'sh0},
		// regular step at rest: 2x - xp = x
		'{1'b1, 2'd1, 1'b1, 32'sh00010000, 32'sh00010000, 32'sh0, 32'sh0, 32'sh0,
			1'b1, 32'sh00010000},
		// previous position over half a box above: unwrap down
		'{1'b1, 2'd2, 1'b0, 32'sh0, 32'sh000927c0, 32'sh0, 32'sh0, 32'sh0, 1'b0, 32'sh0},
		// previous position over half a box below: unwrap up
		'{1'b1, 2'd0, 1'b1, 32'sh000927c0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b0, 32'sh0},
		// displacement of exactly half a box: no unwrap
		'{1'b1, 2'd1, 1'b0, 32'sh00050000, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b0, 32'sh0},
		// force extremes
		'{1'b0, 2'd0, 1'b0, 32'sh00050000, 32'sh0, 32'sh7fffffff, 32'sh0, 32'sh0,
			1'b0, 32'sh0},
		'{1'b0, 2'd1, 1'b1, 32'sh00050000, 32'sh0, 32'sh80000000, 32'sh0, 32'sh0,
			1'b0, 32'sh0},
		// first step ignores the old noise and the previous position
		'{1'b0, 2'd2, 1'b0, 32'sh00050000, 32'sh12345678, 32'sh0, 32'sh7fffffff,
			32'sh12345678, 1'b0, 32'sh0},
		// noise extremes summed on a regular step
		'{1'b1, 2'd0, 1'b1, 32'sh00050000, 32'sh00050000, 32'sh0, 32'sh80000000,
			32'sh80000000, 1'b0, 32'sh0},
		'{1'b1, 2'd1, 1'b0, 32'sh00050000, 32'sh00050000, 32'sh0, 32'sh7fffffff,
			32'sh7fffffff, 1'b0, 32'sh0},
		// halving of an odd negative noise rounds toward minus infinity
		'{1'b1, 2'd2, 1'b1, 32'sh0, 32'sh0, 32'sh0, 32'shffffffff, 32'sh0, 1'b0, 32'sh0},
		// opposite extremes: unwrap stays in range, 2bx saturates
		'{1'b1, 2'd0, 1'b0, 32'sh7fffffff, 32'sh80000000, 32'sh0, 32'sh0, 32'sh0,
			1'b0, 32'sh0},
		'{1'b1, 2'd1, 1'b1, 32'sh80000000, 32'sh7fffffff, 32'sh0, 32'sh0, 32'sh0,
			1'b0, 32'sh0},
		// axis 3 falls back to the z box: 11.0 wraps to 1.0
		'{1'b0, 2'd3, 1'b0, 32'sh000b0000, 32'sh0, 32'sh0, 32'sh0, 32'sh0,
			1'b1, 32'sh00010000},
		'{1'b1, 2'd3, 1'b1, 32'sh0, 32'sh000927c0, 32'sh0, 32'sh0, 32'sh0, 1'b0, 32'sh0},
		// ordinary mixed beats
		'{1'b0, 2'd2, 1'b0, 32'sh00030000, 32'sh0, 32'sh00100000, 32'sh00020000,
			32'sh0, 1'b0, 32'sh0},
		'{1'b1, 2'd0, 1'b1, 32'sh00048000, 32'sh00040000, 32'shfff00000, 32'sh00018000,
			32'shffff0000, 1'b0, 32'sh0}
	};

	langevin_verlet_position_step dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),  // position, prev_position, force_req,
		                                // noise_now, noise_before
		.s_axis_tuser  (s_axis_tuser),  // cmd, axis[1:0], particle_type
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)   // new_position, history_position,
		                                // history_noise
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// ---------------------------------------------------------------- predictor

	function automatic longint clamp_q(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// fixed-point product: floor shift, then clamp to 32 bit signed
	function automatic longint qmul(longint a, longint b);
		return clamp_q((a * b) >>> FRAC);
	endfunction

	// box length for an axis; the unused axis code takes the last box
	function automatic longint axis_box(logic [1:0] ax);
		case (ax)
			2'd0: return longint'(regs_now.box_x);
			2'd1: return longint'(regs_now.box_y);
			default: return longint'(regs_now.box_z);
		endcase
	endfunction

	function automatic logic signed [31:0] verlet_position(coord_beat_t b);
		longint x, xp, span, half, dt_sq, drift, kick, nhalf, amp, total;
		longint ca, cb, dt;
		ca    = longint'(regs_now.coef_a);
		cb    = longint'(regs_now.coef_b);
		dt    = longint'(regs_now.dt);
		x     = longint'(b.pos);
		xp    = longint'(b.prev_pos);
		span  = axis_box(b.axis);
		half  = span >>> 1;
		amp   = b.ptype ? longint'(regs_now.amp1) : longint'(regs_now.amp0);
		dt_sq = qmul(dt, dt);
		drift = qmul(qmul(cb, dt_sq), longint'(b.frc));
		// first step takes half the fresh noise, regular step half the sum
		if (b.regular)
			nhalf = (longint'(b.noise_new) + longint'(b.noise_old)) >>> 1;
		else
			nhalf = longint'(b.noise_new) >>> 1;
		kick = qmul(qmul(qmul(cb, dt), amp), nhalf);
		if (b.regular) begin
			// bring the old coordinate to the same image as the current one
			if (x - xp > half)
				xp = clamp_q(xp + span);
			else if (x - xp < -half)
				xp = clamp_q(xp - span);
			total = clamp_q(2 * qmul(cb, x)) - qmul(ca, xp) + drift + kick;
		end else begin
			total = x + drift + kick;
		end
		total = clamp_q(total);
		// single wrap into the box
		if (total > span)
			total = total - span;
		else if (total < 0)
			total = total + span;
		return total[31:0];
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic verlet_regs_t typical_regs();
		verlet_regs_t r;
		r.coef_a = $urandom_range(65536, 52429);  // 0.8 .. 1.0
		r.coef_b = $urandom_range(72090, 58982);  // 0.9 .. 1.1
		r.dt     = 31'($urandom_range(6554, 1));  // up to 0.1
		r.box_x  = 31'($urandom_range(6553600, 131072));
		r.box_y  = 31'($urandom_range(6553600, 131072));
		r.box_z  = 31'($urandom_range(6553600, 131072));
		r.amp0   = 31'($urandom_range(262144, 0));
		r.amp1   = 31'($urandom_range(262144, 0));
		return r;
	endfunction

	function automatic verlet_regs_t wild_regs();
		verlet_regs_t r;
		r.coef_a = $urandom;
		r.coef_b = $urandom;
		r.dt     = 31'($urandom);
		r.box_x  = 31'($urandom_range(32'h7fffffff, 1));
		r.box_y  = 31'($urandom_range(32'h7fffffff, 1));
		r.box_z  = 31'($urandom_range(32'h7fffffff, 1));
		r.amp0   = 31'($urandom);
		r.amp1   = 31'($urandom);
		return r;
	endfunction

	// Mostly physical beats: coordinate inside its box, previous one nearby or
	// one box image away, moderate force and noise. The rest is raw bits.
	function automatic coord_beat_t random_coord();
		coord_beat_t b;
		longint span, x, xp;
		b.axis  = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
		b.ptype = 1'($urandom_range(1));
		if ($urandom_range(99) < 25) begin
			b.regular   = 1'($urandom_range(1));
			b.pos       = $urandom;
			b.prev_pos  = $urandom;
			b.frc       = $urandom;
			b.noise_new = $urandom;
			b.noise_old = $urandom;
		end else begin
			b.regular = ($urandom_range(9) != 0);
			span      = axis_box(b.axis);
			x         = longint'($urandom_range(32'(span), 0));
			xp        = x + longint'($urandom_range(65536)) - 32768;
			case ($urandom_range(5))
				0: xp = xp + span;
				1: xp = xp - span;
				default: ;
			endcase
			b.pos       = x[31:0];
			b.prev_pos  = xp[31:0];
			b.frc       = int'($urandom_range(32'h0100_0000)) - 32'sh0080_0000;
			b.noise_new = int'($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
			b.noise_old = int'($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
		end
		return b;
	endfunction

	// Call at a falling edge; returns at the falling edge after the write.
	task automatic put_reg(logic [CFG_AW-1:0] idx, logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(negedge clk);
	endtask

	// Write the whole register file; the spare top bit of 31-bit registers
	// gets random junk, which the block must drop.
	task automatic load_regs(verlet_regs_t r, bit stray);
		put_reg(REG_COEF_A, r.coef_a);
		put_reg(REG_COEF_B, r.coef_b);
		put_reg(REG_TIME_STEP, {1'($urandom_range(1)), r.dt});
		put_reg(REG_BOX_X, {1'($urandom_range(1)), r.box_x});
		put_reg(REG_BOX_Y, {1'($urandom_range(1)), r.box_y});
		put_reg(REG_BOX_Z, {1'($urandom_range(1)), r.box_z});
		put_reg(REG_AMP0, {1'($urandom_range(1)), r.amp0});
		put_reg(REG_AMP1, {1'($urandom_range(1)), r.amp1});
		if (stray)
			put_reg(REG_STRAY, $urandom);
		cfg_we   <= 1'b0;
		regs_now  = r;
	endtask

	// Offer one beat from a falling edge, hold it until taken, log what the
	// block owes for it, and return at the next falling edge.
	task automatic offer_beat(coord_beat_t b, bit known, logic signed [31:0] known_pos);
		coord_result_t e;
		while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {b.noise_old, b.noise_new, b.frc, b.prev_pos, b.pos};
		s_axis_tuser  <= {b.ptype, b.axis, b.regular};
		do
			@(posedge clk);
		while (!s_axis_tready);
		e.new_pos    = known ? known_pos : verlet_position(b);
		e.hist_pos   = b.pos;
		e.hist_noise = b.noise_new;
		pending_results.push_back(e);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// ---------------------------------------------------------------- receiver

	// Random stalls, none while no_gaps is set; a hold request forces a long
	// stall so the pipeline fills and backs up into the input.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (holds_taken != hold_reqs) begin
			holds_taken    = hold_reqs;
			hold_left      = HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left      = hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// ---------------------------------------------------------------- checker

	task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
		mismatches = mismatches + 1;
		if (mismatches <= REPORT_MAX)
			$display("mismatch on %s: expected %h, got %h", what, want, got);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_res.new_pos    = m_axis_tdata[31:0];
			got_res.hist_pos   = m_axis_tdata[63:32];
			got_res.hist_noise = m_axis_tdata[95:64];
			if (pending_results.size() == 0) begin
				note_mismatch("unexpected result beat", 32'h0, got_res.new_pos);
			end else begin
				want_res = pending_results.pop_front();
				if (got_res.new_pos !== want_res.new_pos)
					note_mismatch("new_position", want_res.new_pos, got_res.new_pos);
				if (got_res.hist_pos !== want_res.hist_pos)
					note_mismatch("history_position", want_res.hist_pos, got_res.hist_pos);
				if (got_res.hist_noise !== want_res.hist_noise)
					note_mismatch("history_noise", want_res.hist_noise, got_res.hist_noise);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("langevin_verlet_position_step verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		verlet_regs_t r;
		coord_beat_t  b;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_addr      = '0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		no_gaps       = 1'b0;
		regs_now.coef_a = RST_COEF_A;
		regs_now.coef_b = RST_COEF_B;
		regs_now.dt     = RST_TIME_STEP;
		regs_now.box_x  = RST_BOX;
		regs_now.box_y  = RST_BOX;
		regs_now.box_z  = RST_BOX;
		regs_now.amp0   = RST_AMP;
		regs_now.amp1   = RST_AMP;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed beats against the reset register values
		foreach (directed_rows[i]) begin
			b.regular   = directed_rows[i].regular;
			b.axis      = directed_rows[i].axis;
			b.ptype     = directed_rows[i].ptype;
			b.pos       = directed_rows[i].pos;
			b.prev_pos  = directed_rows[i].prev_pos;
			b.frc       = directed_rows[i].frc;
			b.noise_new = directed_rows[i].noise_new;
			b.noise_old = directed_rows[i].noise_old;
			offer_beat(b, directed_rows[i].known, directed_rows[i].known_pos);
		end
		s_axis_tvalid <= 1'b0;
		wait_drained();

		// Register phases: write only with the pipeline empty, then stream.
		for (int p = 0; p < PHASES; p++) begin
			r = typical_regs();
			case (p)
				1: begin
					// all at their top value: everything saturates
					r.coef_a = 32'sh7fffffff;
					r.coef_b = 32'sh7fffffff;
					r.dt     = 31'h7fffffff;
					r.box_x  = 31'h7fffffff;
					r.box_y  = 31'h7fffffff;
					r.box_z  = 31'h7fffffff;
					r.amp0   = 31'h7fffffff;
					r.amp1   = 31'h7fffffff;
				end
				2: begin
					// bottom values: negative coefficients, no time step, unit box
					r.coef_a = 32'sh80000000;
					r.coef_b = 32'sh80000000;
					r.dt     = 31'h0;
					r.box_x  = 31'h1;
					r.box_y  = 31'h1;
					r.box_z  = 31'h1;
					r.amp0   = 31'h0;
					r.amp1   = 31'h0;
				end
				4: begin
					r.coef_a = 32'sh0;
					r.coef_b = 32'sh00010000;
					r.dt     = 31'h7fffffff;
					r.box_x  = 31'h1;
					r.box_y  = 31'h7fffffff;
					r.amp0   = 31'h7fffffff;
					r.amp1   = 31'h0;
				end
				5: begin
					// zero box on y: unwrap and wrap become no-ops there
					r.box_y = 31'h0;
				end
				0, 3: ;
				default: begin
					if ($urandom_range(1))
						r = wild_regs();
				end
			endcase
			load_regs(r, p == 5);
			// first phase runs with no gaps on either side; the fourth starts
			// with a long output stall while input keeps coming
			no_gaps = (p == 0);
			if (p == 3)
				hold_reqs = hold_reqs + 1;
			repeat (PHASE_BEATS)
				offer_beat(random_coord(), 1'b0, 32'sh0);
			s_axis_tvalid <= 1'b0;
			wait_drained();
		end

		// let any stray beat surface before the verdict
		repeat (PIPE_DEPTH * 4) @(negedge clk);
		if (mismatches == 0)
			$display("langevin_verlet_position_step verification clean");
		else
			$display("langevin_verlet_position_step verification failed");
		$finish;
	end

endmodule
